[sv/tsam_pkg.sv]
// Package: payload words, register codes and constants of the touch averaging and mapping block.
package tsam_pkg;

  // Samples averaged per axis
  localparam int unsigned SamplesPerAxisDef = 6;

  // Largest raw ADC code, also the base of axis reversal
  localparam logic [11:0] RAW_MAX = 12'd4095;

  // Register file geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic signed [13:0] X_OFFSET_RST = 14'sd0;
  localparam logic signed [13:0] Y_OFFSET_RST = 14'sd0;
  localparam logic signed [15:0] X_SCALE_RST  = 16'sd1024;
  localparam logic signed [15:0] Y_SCALE_RST  = 16'sd1024;
  localparam logic [12:0]        WIDTH_RST    = 13'd240;
  localparam logic [12:0]        HEIGHT_RST   = 13'd320;
  localparam logic [3:0]         ORIENT_RST   = 4'd0;

  // Largest usable screen size
  localparam logic [12:0] SIZE_MAX = 13'd4096;

  // Orientation flag bit positions
  localparam int unsigned OrSwap   = 0;
  localparam int unsigned OrRevX   = 1;
  localparam int unsigned OrRevY   = 2;
  localparam int unsigned OrMirror = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_OFFSET = 3'd0,
    CFG_Y_OFFSET = 3'd1,
    CFG_X_SCALE  = 3'd2,
    CFG_Y_SCALE  = 3'd3,
    CFG_WIDTH    = 3'd4,
    CFG_HEIGHT   = 3'd5,
    CFG_ORIENT   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic        pen_down;
    logic [11:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic        touched;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } out_word_t;

endpackage

[sv/touch_sample_average_and_map_top.sv]
// Top level: touch sample averaging, orientation and linear screen mapping.
// Result path: a pen-up word or the last Y sample of a frame gives its result word,
//   registered in stages 1, 2, 3 and the output stage; other sample words give no result.
// Throughput: one word per cycle through four registered stages (sums, averages,
//   scaled products, output word); a stalled output backs the stages up to the input.
// Reset (async, low): counts, sums, valids cleared; offset 0, gain 1024, 240 x 320, no flags.
module touch_sample_average_and_map_top #(
  parameter int unsigned SAMPLES_PER_AXIS = tsam_pkg::SamplesPerAxisDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample stream
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tsam_pkg::in_word_t              in_data_i,
  // result stream
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tsam_pkg::out_word_t             out_data_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tsam_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tsam_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tsam_pkg::*;

  // Widths that follow from the frame length
  localparam int unsigned N     = SAMPLES_PER_AXIS;
  localparam int unsigned SumW  = 12 + $clog2(N);
  localparam int unsigned CntW  = (2 * N > 1) ? $clog2(2 * N) : 1;
  // Divide by N as multiply by a rounded-up reciprocal; exact for any SumW-bit sum
  localparam int unsigned RecSh = SumW + $clog2(N);
  localparam longint unsigned RecVal = ((64'd1 << RecSh) + N - 1) / N;
  localparam int unsigned RecW  = RecSh + 1;
  localparam int unsigned ProdW = SumW + RecW;
  localparam logic [RecW-1:0] RECIP   = RecW'(RecVal);
  localparam logic [CntW:0]   CNT_X   = (CntW+1)'(N);
  localparam logic [CntW:0]   CNT_ALL = (CntW+1)'(2 * N);

  // ---------------------------------------------------------------------------
  // Registers. Writes wait until no result word is in the stages or on the
  // output, so later stages read them directly.
  // ---------------------------------------------------------------------------
  logic signed [13:0] x_off_q, y_off_q;
  logic signed [15:0] x_scl_q, y_scl_q;
  logic [12:0]        width_q, height_q;
  logic [3:0]         orient_q;
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;

  assign cfg_ready_o = !(s1_v_q || s2_v_q || s3_v_q || out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q  <= X_OFFSET_RST;
      y_off_q  <= Y_OFFSET_RST;
      x_scl_q  <= X_SCALE_RST;
      y_scl_q  <= Y_SCALE_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      orient_q <= ORIENT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_X_OFFSET: x_off_q  <= cfg_data_i[13:0];
        CFG_Y_OFFSET: y_off_q  <= cfg_data_i[13:0];
        CFG_X_SCALE:  x_scl_q  <= cfg_data_i;
        CFG_Y_SCALE:  y_scl_q  <= cfg_data_i;
        CFG_WIDTH:    width_q  <= cfg_data_i[12:0];
        CFG_HEIGHT:   height_q <= cfg_data_i[12:0];
        CFG_ORIENT:   orient_q <= cfg_data_i[3:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow: each stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------------
  logic ld_out, s3_free, s2_free, s1_free;

  assign ld_out  = !out_v_q || out_ready_i;
  assign s3_free = !s3_v_q  || ld_out;
  assign s2_free = !s2_v_q  || s3_free;
  assign s1_free = !s1_v_q  || s2_free;

  assign in_ready_o = s1_free;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Accumulator: X sum is kept whole, divided only once the frame completes.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d, xsum_q, xsum_d;
  logic [CntW:0]   cnt_inc;
  logic [SumW-1:0] sum_inc;
  logic            push;   // word heads into the result stages

  always_comb begin
    cnt_inc = {1'b0, cnt_q} + (CntW+1)'(1);
    sum_inc = sum_q + SumW'(in_data_i.adc_sample);
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    xsum_d  = xsum_q;
    push    = 1'b0;
    if (in_acc) begin
      if (!in_data_i.pen_down) begin
        // pen released: restart the frame, report no touch
        cnt_d  = '0;
        sum_d  = '0;
        xsum_d = '0;
        push   = 1'b1;
      end else if (cnt_inc == CNT_X) begin
        // last X sample
        xsum_d = sum_inc;
        sum_d  = '0;
        cnt_d  = cnt_inc[CntW-1:0];
      end else if (cnt_inc == CNT_ALL) begin
        // last Y sample: frame complete
        cnt_d = '0;
        sum_d = '0;
        push  = 1'b1;
      end else begin
        cnt_d = cnt_inc[CntW-1:0];
        sum_d = sum_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      xsum_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      xsum_q <= xsum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: both axis sums of a finished frame, or a pen-up (no-touch) word.
  // ---------------------------------------------------------------------------
  logic            s1_touch_q;
  logic [SumW-1:0] s1_xsum_q, s1_ysum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && push) begin
      s1_touch_q <= in_data_i.pen_down;
      s1_xsum_q  <= xsum_q;
      s1_ysum_q  <= sum_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: averages, by reciprocal multiply (floor of sum / N).
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] xq_prod, yq_prod;
  logic             s2_touch_q;
  logic [11:0]      s2_rx_q, s2_ry_q;

  assign xq_prod = ProdW'(s1_xsum_q) * ProdW'(RECIP);
  assign yq_prod = ProdW'(s1_ysum_q) * ProdW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_v_q) begin
      s2_touch_q <= s1_touch_q;
      s2_rx_q    <= xq_prod[RecSh +: 12];
      s2_ry_q    <= yq_prod[RecSh +: 12];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: swap, reverse, offset and gain.
  // ---------------------------------------------------------------------------
  logic [11:0]        ax, ay;
  logic signed [14:0] dx, dy;
  logic signed [30:0] px, py;
  logic               s3_touch_q;
  logic signed [30:0] s3_px_q, s3_py_q;

  always_comb begin
    ax = orient_q[OrSwap] ? s2_ry_q : s2_rx_q;
    ay = orient_q[OrSwap] ? s2_rx_q : s2_ry_q;
    if (orient_q[OrRevX]) ax = RAW_MAX - ax;
    if (orient_q[OrRevY]) ay = RAW_MAX - ay;
    dx = $signed({3'b000, ax}) - $signed({x_off_q[13], x_off_q});
    dy = $signed({3'b000, ay}) - $signed({y_off_q[13], y_off_q});
    px = 31'(dx) * 31'(x_scl_q);
    py = 31'(dy) * 31'(y_scl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_free) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_v_q) begin
      s3_touch_q <= s2_touch_q;
      s3_px_q    <= px;
      s3_py_q    <= py;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: floor shift by 10, optional mirror, clamp to the screen.
  // ---------------------------------------------------------------------------
  logic [12:0]        w_eff, h_eff;
  logic signed [20:0] vx, vy;
  logic signed [22:0] mx, wide_w, wide_h;
  logic [11:0]        cx, cy;
  out_word_t          out_q, out_d;

  always_comb begin
    // zero size acts as one pixel, anything above 4096 as 4096
    if (width_q == '0)          w_eff = 13'd1;
    else if (width_q > SIZE_MAX) w_eff = SIZE_MAX;
    else                         w_eff = width_q;
    if (height_q == '0)           h_eff = 13'd1;
    else if (height_q > SIZE_MAX) h_eff = SIZE_MAX;
    else                          h_eff = height_q;

    vx     = s3_px_q[30:10];
    vy     = s3_py_q[30:10];
    wide_w = $signed({10'b0, w_eff});
    wide_h = $signed({10'b0, h_eff});
    mx     = orient_q[OrMirror] ? (wide_w - 23'sd1 - 23'(vx)) : 23'(vx);

    if (mx < 0)            cx = '0;
    else if (mx >= wide_w) cx = 12'(w_eff - 13'd1);
    else                   cx = mx[11:0];

    if (vy < 0)                 cy = '0;
    else if (23'(vy) >= wide_h) cy = 12'(h_eff - 13'd1);
    else                        cy = vy[11:0];

    out_d.touched = s3_touch_q;
    out_d.pixel_x = s3_touch_q ? cx : '0;
    out_d.pixel_y = s3_touch_q ? cy : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ld_out) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out && s3_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // frame counter stays inside one X+Y frame
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} < CNT_ALL)
    else $error("sample count left the frame");

  // a pen-up word always lands in stage 1
  a_penup_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.pen_down) |=> s1_v_q)
    else $error("pen-up word lost");

  // no-touch words carry zero coordinates
  a_notouch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.touched) |-> (out_q.pixel_x == '0 && out_q.pixel_y == '0))
    else $error("no-touch word with coordinates");

  // touch coordinates stay on the screen
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.touched) |->
      ({1'b0, out_q.pixel_x} < w_eff && {1'b0, out_q.pixel_y} < h_eff))
    else $error("coordinate off screen");
`endif

endmodule
